// ===== rtl/core/fdtd_pkg.sv =====
// Shared types and constants for the Ez field update block.
// Used by the controller, the datapath and the top level; no dependencies.
package fdtd_pkg;

    // Input action codes, echoed on the result as its kind
    localparam logic [1:0] ACT_UPDATE   = 2'd0;
    localparam logic [1:0] ACT_BOUNDARY = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_UNDEF    = 2'd3;

    // Boundary pass kinds
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_PEC  = 2'd1;
    localparam logic [1:0] MODE_MUR  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_COE_EZ   = 3'd0;
    localparam logic [2:0] REG_COE_MUR  = 3'd1;
    localparam logic [2:0] REG_BND_MODE = 3'd2;
    localparam logic [2:0] REG_ROWS     = 3'd3;
    localparam logic [2:0] REG_COLS     = 3'd4;

    localparam int COORD_W = 6;
    localparam int VAL_W   = 32;
    localparam int MUR_W   = 18;
    localparam int DIM_REG_W = 7;

    // Boundary edge being walked; also selects the history bank
    typedef enum logic [1:0] {
        PH_UP    = 2'd0,
        PH_DOWN  = 2'd1,
        PH_LEFT  = 2'd2,
        PH_RIGHT = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR,
        DP_LATCH,
        DP_CELL_RD,
        DP_UPD_MUL,
        DP_UPD_WR,
        DP_RD_GET,
        DP_PEC_WR,
        DP_MUR_RD,
        DP_MUR_DIFF,
        DP_MUR_MUL,
        DP_MUR_WR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        t_phase phase;
    } t_ctl_cmd;

    typedef struct packed {
        logic in_area;
        logic clr_last;
    } t_dp_status;

endpackage

// ===== rtl/core/fdtd_dp.sv =====
// Datapath: Ez grid memory, Mur history memories, update and Mur arithmetic.
// Depends on fdtd_pkg; driven by fdtd_ctl commands.
module fdtd_dp #(
    parameter int ROWS      = 64,
    parameter int COLS      = 64,
    parameter int FRAC_BITS = 16,
    localparam int MAXD = (ROWS > COLS) ? ROWS : COLS,
    localparam int XW   = $clog2(MAXD),
    localparam int DW   = $clog2(MAXD + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fdtd_pkg::t_ctl_cmd          i_cmd,
    input  logic [XW-1:0]               i_idx,
    input  logic [DW-1:0]               i_nr,
    input  logic [DW-1:0]               i_nc,
    input  logic [31:0]                 i_coe_ez,
    input  logic signed [17:0]          i_coe_mur,
    input  logic [1:0]                  i_action,
    input  logic [5:0]                  i_row,
    input  logic [5:0]                  i_col,
    input  logic signed [31:0]          i_hx_left,
    input  logic signed [31:0]          i_hx_here,
    input  logic signed [31:0]          i_hy_here,
    input  logic signed [31:0]          i_hy_below,
    output fdtd_pkg::t_dp_status        o_status,
    output logic [1:0]                  o_kind,
    output logic signed [31:0]          o_value
);

    localparam int GRID   = ROWS * COLS;
    localparam int GAW    = $clog2(GRID);
    localparam int HAW    = XW + 2;
    localparam int HDEPTH = 1 << HAW;
    localparam int CLR_LEN = (GRID > HDEPTH) ? GRID : HDEPTH;
    localparam int CLW    = $clog2(CLR_LEN);
    localparam int CW1    = CLW + 1;
    localparam int CW     = (DW > 7) ? DW : 7;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    logic signed [31:0] r_grid [GRID];
    logic signed [31:0] r_eprev_mem [HDEPTH];
    logic signed [31:0] r_iprev_mem [HDEPTH];

    logic signed [31:0] r_grd;
    logic signed [31:0] r_eprev_rd;
    logic signed [31:0] r_iprev_rd;
    logic [CLW-1:0]     r_clr_cnt;
    logic [GAW-1:0]     r_cell_addr;
    logic signed [31:0] r_hs;
    logic signed [31:0] r_ez;
    logic signed [64:0] r_p;
    logic signed [31:0] r_inner;
    logic signed [31:0] r_iprev;
    logic signed [32:0] r_d;
    logic signed [50:0] r_pm;
    logic [1:0]         r_kind;
    logic signed [31:0] r_res;

    logic signed [33:0] w_hs34;
    logic signed [32:0] w_coe_s;
    logic signed [31:0] w_upd_new;
    logic signed [31:0] w_mur_new;
    logic [XW-1:0]      w_er, w_ec, w_ir, w_ic;
    logic [GAW-1:0]     w_eaddr, w_iaddr;
    logic [HAW-1:0]     w_haddr;
    logic               w_gwe, w_gre, w_hwe;
    logic [GAW-1:0]     w_gwaddr, w_graddr;
    logic signed [31:0] w_gwdata;
    logic               w_clr_grid, w_clr_hist;

    assign w_hs34 = 34'(i_hx_left) - 34'(i_hx_here) + 34'(i_hy_here) - 34'(i_hy_below);
    assign w_coe_s = {1'b0, i_coe_ez};
    assign w_upd_new = sat32(66'(r_ez) + ((66'(r_p) + HALF) >>> FRAC_BITS));
    assign w_mur_new = sat32(66'(r_iprev) + ((66'(r_pm) + HALF) >>> FRAC_BITS));

    // Edge cell and its inner neighbor for the current boundary position
    always_comb begin
        unique case (i_cmd.phase)
            fdtd_pkg::PH_UP: begin
                w_er = XW'(i_nr - DW'(1));
                w_ir = XW'(i_nr - DW'(2));
                w_ec = i_idx;
                w_ic = i_idx;
            end
            fdtd_pkg::PH_DOWN: begin
                w_er = '0;
                w_ir = XW'(1);
                w_ec = i_idx;
                w_ic = i_idx;
            end
            fdtd_pkg::PH_LEFT: begin
                w_er = i_idx;
                w_ir = i_idx;
                w_ec = '0;
                w_ic = XW'(1);
            end
            default: begin
                w_er = i_idx;
                w_ir = i_idx;
                w_ec = XW'(i_nc - DW'(1));
                w_ic = XW'(i_nc - DW'(2));
            end
        endcase
    end

    assign w_eaddr = GAW'(w_er) * GAW'(COLS) + GAW'(w_ec);
    assign w_iaddr = GAW'(w_ir) * GAW'(COLS) + GAW'(w_ic);
    assign w_haddr = {i_cmd.phase, i_idx};

    assign w_clr_grid = {1'b0, r_clr_cnt} < CW1'(GRID);
    assign w_clr_hist = {1'b0, r_clr_cnt} < CW1'(HDEPTH);

    always_comb begin
        w_gwe    = 1'b0;
        w_gre    = 1'b0;
        w_hwe    = 1'b0;
        w_gwaddr = w_eaddr;
        w_graddr = r_cell_addr;
        w_gwdata = '0;
        unique case (i_cmd.op)
            fdtd_pkg::DP_CLR: begin
                w_gwe    = w_clr_grid;
                w_hwe    = w_clr_hist;
                w_gwaddr = r_clr_cnt[GAW-1:0];
            end
            fdtd_pkg::DP_CELL_RD: w_gre = 1'b1;
            fdtd_pkg::DP_UPD_WR: begin
                w_gwe    = 1'b1;
                w_gwaddr = r_cell_addr;
                w_gwdata = w_upd_new;
            end
            fdtd_pkg::DP_PEC_WR: w_gwe = 1'b1;
            fdtd_pkg::DP_MUR_RD: begin
                w_gre    = 1'b1;
                w_graddr = w_iaddr;
            end
            fdtd_pkg::DP_MUR_WR: begin
                w_gwe    = 1'b1;
                w_hwe    = 1'b1;
                w_gwdata = w_mur_new;
            end
            default: ;
        endcase
    end

    // Grid memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_gwe) begin
            r_grid[w_gwaddr] <= w_gwdata;
        end
        if (w_gre) begin
            r_grd <= r_grid[w_graddr];
        end
    end

    // Mur history memories, banked by edge
    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            if (i_cmd.op == fdtd_pkg::DP_CLR) begin
                r_eprev_mem[r_clr_cnt[HAW-1:0]] <= '0;
                r_iprev_mem[r_clr_cnt[HAW-1:0]] <= '0;
            end else begin
                r_eprev_mem[w_haddr] <= w_mur_new;
                r_iprev_mem[w_haddr] <= r_inner;
            end
        end
        if (i_cmd.op == fdtd_pkg::DP_MUR_RD) begin
            r_eprev_rd <= r_eprev_mem[w_haddr];
            r_iprev_rd <= r_iprev_mem[w_haddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.op == fdtd_pkg::DP_CLR) begin
            r_clr_cnt <= r_clr_cnt + CLW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            fdtd_pkg::DP_LATCH: begin
                r_kind      <= i_action;
                r_res       <= '0;
                r_hs        <= sat32(66'(w_hs34));
                r_cell_addr <= GAW'(XW'(i_row)) * GAW'(COLS) + GAW'(XW'(i_col));
            end
            fdtd_pkg::DP_UPD_MUL: begin
                r_ez <= r_grd;
                r_p  <= r_hs * w_coe_s;
            end
            fdtd_pkg::DP_UPD_WR: r_res <= w_upd_new;
            fdtd_pkg::DP_RD_GET: r_res <= r_grd;
            fdtd_pkg::DP_MUR_DIFF: begin
                r_inner <= r_grd;
                r_d     <= 33'(r_grd) - 33'(r_eprev_rd);
                r_iprev <= r_iprev_rd;
            end
            fdtd_pkg::DP_MUR_MUL: r_pm <= i_coe_mur * r_d;
            default: ;
        endcase
    end

    assign o_status.in_area  = (CW'(i_row) < CW'(i_nr)) && (CW'(i_col) < CW'(i_nc));
    assign o_status.clr_last = (r_clr_cnt == CLW'(CLR_LEN - 1));
    assign o_kind  = r_kind;
    assign o_value = r_res;

endmodule

// ===== rtl/core/fdtd_ctl.sv =====
// Controller: sequences clear, cell update, read and boundary passes.
// Depends on fdtd_pkg; issues commands to fdtd_dp.
module fdtd_ctl #(
    parameter int ROWS = 64,
    parameter int COLS = 64,
    localparam int MAXD = (ROWS > COLS) ? ROWS : COLS,
    localparam int XW   = $clog2(MAXD),
    localparam int DW   = $clog2(MAXD + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [1:0]             i_action,
    input  logic [1:0]             i_mode,
    input  logic [DW-1:0]          i_nr,
    input  logic [DW-1:0]          i_nc,
    input  fdtd_pkg::t_dp_status   i_status,
    input  logic                   i_out_free,
    output logic                   o_in_ready,
    output logic                   o_out_load,
    output fdtd_pkg::t_ctl_cmd     o_cmd,
    output logic [XW-1:0]          o_idx
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_RD,
        S_UPD_MUL,
        S_UPD_WR,
        S_RD,
        S_RD_GET,
        S_PEC,
        S_MUR_RD,
        S_MUR_DIFF,
        S_MUR_MUL,
        S_MUR_WR,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    fdtd_pkg::t_phase r_phase, n_phase;
    logic [XW-1:0]    r_idx, n_idx;
    logic             w_accept;
    logic             w_last;
    logic             w_pass_end;
    fdtd_pkg::t_phase w_adv_phase;
    logic [XW-1:0]    w_adv_idx;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    assign o_out_load = (r_state == S_DONE) && i_out_free;

    // End of the current edge walk
    assign w_last = (r_phase == fdtd_pkg::PH_UP || r_phase == fdtd_pkg::PH_DOWN) ?
                    (DW'(r_idx) == i_nc - DW'(1)) : (DW'(r_idx) == i_nr - DW'(1));
    assign w_pass_end = (r_phase == fdtd_pkg::PH_RIGHT) && w_last;

    // Order: upper row, lower row, then left/right pairs row by row
    always_comb begin
        w_adv_phase = r_phase;
        w_adv_idx   = r_idx + XW'(1);
        unique case (r_phase)
            fdtd_pkg::PH_UP: begin
                if (w_last) begin
                    w_adv_phase = fdtd_pkg::PH_DOWN;
                    w_adv_idx   = '0;
                end
            end
            fdtd_pkg::PH_DOWN: begin
                if (w_last) begin
                    w_adv_phase = fdtd_pkg::PH_LEFT;
                    w_adv_idx   = '0;
                end
            end
            fdtd_pkg::PH_LEFT: begin
                w_adv_phase = fdtd_pkg::PH_RIGHT;
                w_adv_idx   = r_idx;
            end
            default: w_adv_phase = fdtd_pkg::PH_LEFT;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        o_cmd.op = fdtd_pkg::DP_NOP;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = fdtd_pkg::DP_CLR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_phase = fdtd_pkg::PH_UP;
                n_idx   = '0;
                if (w_accept) begin
                    o_cmd.op = fdtd_pkg::DP_LATCH;
                    priority if (i_action == fdtd_pkg::ACT_UPDATE && i_status.in_area) begin
                        n_state = S_UPD_RD;
                    end else if (i_action == fdtd_pkg::ACT_READ && i_status.in_area) begin
                        n_state = S_RD;
                    end else if (i_action == fdtd_pkg::ACT_BOUNDARY &&
                                 i_mode == fdtd_pkg::MODE_PEC) begin
                        n_state = S_PEC;
                    end else if (i_action == fdtd_pkg::ACT_BOUNDARY &&
                                 i_mode == fdtd_pkg::MODE_MUR) begin
                        n_state = S_MUR_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_UPD_RD: begin
                o_cmd.op = fdtd_pkg::DP_CELL_RD;
                n_state  = S_UPD_MUL;
            end
            S_UPD_MUL: begin
                o_cmd.op = fdtd_pkg::DP_UPD_MUL;
                n_state  = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_cmd.op = fdtd_pkg::DP_UPD_WR;
                n_state  = S_DONE;
            end
            S_RD: begin
                o_cmd.op = fdtd_pkg::DP_CELL_RD;
                n_state  = S_RD_GET;
            end
            S_RD_GET: begin
                o_cmd.op = fdtd_pkg::DP_RD_GET;
                n_state  = S_DONE;
            end
            S_PEC: begin
                o_cmd.op = fdtd_pkg::DP_PEC_WR;
                n_phase  = w_adv_phase;
                n_idx    = w_adv_idx;
                if (w_pass_end) begin
                    n_state = S_DONE;
                end
            end
            S_MUR_RD: begin
                o_cmd.op = fdtd_pkg::DP_MUR_RD;
                n_state  = S_MUR_DIFF;
            end
            S_MUR_DIFF: begin
                o_cmd.op = fdtd_pkg::DP_MUR_DIFF;
                n_state  = S_MUR_MUL;
            end
            S_MUR_MUL: begin
                o_cmd.op = fdtd_pkg::DP_MUR_MUL;
                n_state  = S_MUR_WR;
            end
            S_MUR_WR: begin
                o_cmd.op = fdtd_pkg::DP_MUR_WR;
                n_phase  = w_adv_phase;
                n_idx    = w_adv_idx;
                n_state  = w_pass_end ? S_DONE : S_MUR_RD;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.phase = r_phase;
    assign o_idx       = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_phase <= fdtd_pkg::PH_UP;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== rtl/core/fdtd_ez_field_update_with_boundary.sv =====
// Top level of the 2D Ez field update block with PEC / first-order Mur boundary.
// Depends on fdtd_pkg, fdtd_ctl and fdtd_dp.
//
// One transaction at a time. After reset the block sweeps the grid and the
// Mur history, one entry per cycle, and accepts no input meanwhile; register
// writes work. Then a cell update steps through read, multiply and
// round/saturate/write through one grid memory port, a cell read returns the
// stored value, an idle boundary pass or out-of-area cell only returns a result,
// a PEC pass makes one grid write per cycle and a Mur pass takes each edge cell
// through read, difference, multiply and write, serialized because later cells
// read earlier results. A finished result sits in an output register so the
// next transaction is accepted while it waits.
module fdtd_ez_field_update_with_boundary #(
    parameter int ROWS      = 64,
    parameter int COLS      = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // stream in
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // row[5:0], col[11:6], hx_left[43:12], hx_here[75:44],
    // hy_here[107:76], hy_below[139:108], zero pad [143:140]
    input  logic [143:0]  s_axis_tdata,
    // action[1:0]
    input  logic [1:0]    s_axis_tuser,
    // stream out
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // field_value[31:0]
    output logic [31:0]   m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]    m_axis_tuser,
    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int MAXD = (ROWS > COLS) ? ROWS : COLS;
    localparam int XW   = $clog2(MAXD);
    localparam int DW   = $clog2(MAXD + 1);
    localparam int CW   = (DW > 7) ? DW : 7;

    // Configuration registers
    logic [31:0]        r_coe_ez;
    logic signed [17:0] r_coe_mur;
    logic [1:0]         r_mode;
    logic [6:0]         r_rows;
    logic [6:0]         r_cols;

    // Output register
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [31:0]        r_out_val;

    logic               w_wr;
    logic [2:0]         w_reg;
    logic [CW-1:0]      w_rows_x, w_cols_x;
    logic [DW-1:0]      w_nr, w_nc;
    logic               w_out_free;
    logic               w_out_load;
    logic [XW-1:0]      w_idx;
    logic [1:0]         w_kind;
    logic signed [31:0] w_value;
    fdtd_pkg::t_ctl_cmd   w_cmd;
    fdtd_pkg::t_dp_status w_status;

    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coe_ez  <= 32'd65536;
            r_coe_mur <= '0;
            r_mode    <= fdtd_pkg::MODE_NONE;
            r_rows    <= 7'd64;
            r_cols    <= 7'd64;
        end else if (w_wr) begin
            unique case (w_reg)
                fdtd_pkg::REG_COE_EZ:   r_coe_ez  <= pwdata;
                fdtd_pkg::REG_COE_MUR:  r_coe_mur <= pwdata[17:0];
                fdtd_pkg::REG_BND_MODE: r_mode    <= pwdata[1:0];
                fdtd_pkg::REG_ROWS:     r_rows    <= pwdata[6:0];
                fdtd_pkg::REG_COLS:     r_cols    <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            fdtd_pkg::REG_COE_EZ:   prdata = r_coe_ez;
            fdtd_pkg::REG_COE_MUR:  prdata = 32'(r_coe_mur);
            fdtd_pkg::REG_BND_MODE: prdata = {30'd0, r_mode};
            fdtd_pkg::REG_ROWS:     prdata = {25'd0, r_rows};
            fdtd_pkg::REG_COLS:     prdata = {25'd0, r_cols};
            default:                prdata = '0;
        endcase
    end

    // Grid size in use, clamped to [3, ROWS] x [3, COLS]
    assign w_rows_x = CW'(r_rows);
    assign w_cols_x = CW'(r_cols);
    always_comb begin
        if (w_rows_x < CW'(3)) begin
            w_nr = DW'(3);
        end else if (w_rows_x > CW'(ROWS)) begin
            w_nr = DW'(ROWS);
        end else begin
            w_nr = DW'(w_rows_x);
        end
        if (w_cols_x < CW'(3)) begin
            w_nc = DW'(3);
        end else if (w_cols_x > CW'(COLS)) begin
            w_nc = DW'(COLS);
        end else begin
            w_nc = DW'(w_cols_x);
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    fdtd_ctl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .i_mode     (r_mode),
        .i_nr       (w_nr),
        .i_nc       (w_nc),
        .i_status   (w_status),
        .i_out_free (w_out_free),
        .o_in_ready (s_axis_tready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    fdtd_dp #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_idx      (w_idx),
        .i_nr       (w_nr),
        .i_nc       (w_nc),
        .i_coe_ez   (r_coe_ez),
        .i_coe_mur  (r_coe_mur),
        .i_action   (s_axis_tuser),
        .i_row      (s_axis_tdata[5:0]),
        .i_col      (s_axis_tdata[11:6]),
        .i_hx_left  (s_axis_tdata[43:12]),
        .i_hx_here  (s_axis_tdata[75:44]),
        .i_hy_here  (s_axis_tdata[107:76]),
        .i_hy_below (s_axis_tdata[139:108]),
        .o_status   (w_status),
        .o_kind     (w_kind),
        .o_value    (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind <= w_kind;
            r_out_val  <= w_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = r_out_kind;

    // One transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a transaction is in flight");

    // A result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("pending result overwritten");

    // Boundary passes always report zero
    a_bnd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == fdtd_pkg::ACT_BOUNDARY) |-> (m_axis_tdata == 32'd0))
        else $error("boundary pass result not zero");

endmodule
